FILE: hw/rtl/servo_status_packet_receiver_assert.svh
// Assertion macros shared by the servo status packet receiver RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef SERVO_STATUS_PACKET_RECEIVER_ASSERT_SVH
`define SERVO_STATUS_PACKET_RECEIVER_ASSERT_SVH

`ifndef ASSERT_OFF
// Check c whenever a holds in the same cycle.
`define SSPR_ASSERT_IMPLY(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error(msg);
// Check c in the cycle after a holds.
`define SSPR_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error(msg);
`else
`define SSPR_ASSERT_IMPLY(label, clk, rst_n, a, c, msg)
`define SSPR_ASSERT_NEXT(label, clk, rst_n, a, c, msg)
`endif

`endif

FILE: hw/rtl/sspr_pkg.sv
// Shared types and constants of the servo status packet receiver.
// No dependencies; used by the interfaces, the core and the top level.
`default_nettype none

package sspr_pkg;

    localparam int KIND_W  = 2;
    localparam int BYTE_W  = 8;
    localparam int POS_W   = 9;
    localparam int TICK_W  = 16;

    typedef logic [KIND_W-1:0] t_kind;
    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [TICK_W-1:0] t_ticks;

    localparam t_kind KIND_ARM  = 2'd0;
    localparam t_kind KIND_BYTE = 2'd1;
    localparam t_kind KIND_TICK = 2'd2;

    localparam t_ticks TIMEOUT_RESET = 16'd1000;
    localparam t_ticks TICKS_MAX     = 16'hFFFF;

    // Fixed positions inside the status packet.
    localparam t_pos POS_ID      = 9'd2;
    localparam t_pos POS_LENGTH  = 9'd3;
    localparam t_pos POS_PAYLOAD = 9'd4;
    localparam t_pos POS_MAX     = 9'd258;

    typedef struct packed {
        t_byte data_byte;
        t_pos  byte_index;
        logic  packet_done;
        logic  checksum_error;
        logic  timed_out;
    } t_result;

endpackage

`default_nettype wire

FILE: hw/rtl/sspr_if.sv
// Valid/ready channels of the servo status packet receiver.
// Depends on sspr_pkg.
`default_nettype none

interface sspr_item_if import sspr_pkg::*;;
    logic  valid;
    logic  ready;
    t_kind kind;
    t_byte rx_byte;
    modport source (output valid, output kind, output rx_byte, input ready);
    modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface sspr_result_if import sspr_pkg::*;;
    logic  valid;
    logic  ready;
    t_byte data_byte;
    t_pos  byte_index;
    logic  packet_done;
    logic  checksum_error;
    logic  timed_out;
    modport source (output valid, output data_byte, output byte_index, output packet_done,
                    output checksum_error, output timed_out, input ready);
    modport sink   (input valid, input data_byte, input byte_index, input packet_done,
                    input checksum_error, input timed_out, output ready);
endinterface

interface sspr_cfg_if import sspr_pkg::*;;
    logic   valid;
    logic   ready;
    t_ticks timeout_ticks;
    modport source (output valid, output timeout_ticks, input ready);
    modport sink   (input valid, input timeout_ticks, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/servo_status_packet_receiver.sv
// Top level of the servo status packet receiver: input register, result register, config.
// Depends on sspr_pkg, sspr_if, sspr_core and the assertion macro header.
//
//   channel   dir   handshake      payload
//   i_item    in    valid/ready    kind, rx_byte
//   o_result  out   valid/ready    data_byte, byte_index, packet_done, checksum_error, timed_out
//   i_cfg     in    valid/ready    timeout_ticks (always ready)
//
// One item per cycle unless the sink stalls; each item is registered, then so is its result.
// The input register advances when its item gives no result or the result register
// is empty or being taken, so a stalled sink backs up through one item of storage.
// Synchronous active-low reset: receiver idle, timeout limit back to 1000 ticks.
`default_nettype none
`include "servo_status_packet_receiver_assert.svh"

module servo_status_packet_receiver import sspr_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    sspr_item_if.sink    i_item,
    sspr_result_if.source o_result,
    sspr_cfg_if.sink     i_cfg
);

    logic    r_in_valid;
    t_kind   r_in_kind;
    t_byte   r_in_byte;
    logic    r_out_valid;
    t_result r_out;
    t_ticks  r_timeout;

    logic    w_has_result;
    t_result w_result;
    logic    w_advance;

    assign w_advance = r_in_valid && (!w_has_result || !r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || w_advance;
    assign i_cfg.ready  = 1'b1;

    sspr_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (r_in_valid),
        .i_fire          (w_advance),
        .i_kind          (r_in_kind),
        .i_rx_byte       (r_in_byte),
        .i_timeout_ticks (r_timeout),
        .o_has_result    (w_has_result),
        .o_result        (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg.valid) begin
            r_timeout <= i_cfg.timeout_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in_kind <= i_item.kind;
            r_in_byte <= i_item.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_has_result) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_has_result) begin
            r_out <= w_result;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.data_byte      = r_out.data_byte;
    assign o_result.byte_index     = r_out.byte_index;
    assign o_result.packet_done    = r_out.packet_done;
    assign o_result.checksum_error = r_out.checksum_error;
    assign o_result.timed_out      = r_out.timed_out;

    `SSPR_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !w_advance, r_in_valid && $stable(r_in_kind) && $stable(r_in_byte), "stalled input item changed")
    `SSPR_ASSERT_IMPLY(a_one_end, i_clk, i_rst_n, r_out_valid, !(r_out.packet_done && r_out.timed_out), "result both done and timed out")

endmodule

`default_nettype wire

FILE: hw/rtl/sspr_core.sv
// Receive state and per-item update of the status packet receiver.
// Depends on sspr_pkg and the assertion macro header.
`default_nettype none
`include "servo_status_packet_receiver_assert.svh"

module sspr_core import sspr_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire logic    i_fire,
    input  wire t_kind   i_kind,
    input  wire t_byte   i_rx_byte,
    input  wire t_ticks  i_timeout_ticks,
    output logic         o_has_result,
    output t_result      o_result
);

    logic   r_armed,  n_armed;
    t_pos   r_pos,    n_pos;
    t_byte  r_length, n_length;
    t_byte  r_sum,    n_sum;
    t_ticks r_ticks,  n_ticks;

    t_ticks w_ticks_inc;
    t_pos   w_last_pos;
    logic   w_done;
    logic   w_err;

    assign w_ticks_inc = (r_ticks == TICKS_MAX) ? r_ticks : r_ticks + 16'd1;
    assign w_last_pos  = {1'b0, r_length} + POS_LENGTH;

    always_comb begin
        n_armed      = r_armed;
        n_pos        = r_pos;
        n_length     = r_length;
        n_sum        = r_sum;
        n_ticks      = r_ticks;
        o_has_result = 1'b0;
        o_result     = '0;
        w_done       = 1'b0;
        w_err        = 1'b0;

        case (i_kind)
            KIND_ARM: begin
                n_armed  = 1'b1;
                n_pos    = '0;
                n_length = '0;
                n_sum    = '0;
                n_ticks  = '0;
            end
            KIND_TICK: begin
                if (r_armed) begin
                    n_ticks = w_ticks_inc;
                    if (w_ticks_inc >= i_timeout_ticks) begin
                        o_has_result      = 1'b1;
                        o_result.byte_index = r_pos;
                        o_result.timed_out  = 1'b1;
                        n_armed = 1'b0;
                        n_ticks = '0;
                        n_pos   = '0;
                    end
                end
            end
            KIND_BYTE: begin
                if (r_armed) begin
                    n_ticks = '0;
                    if (r_pos == POS_ID) begin
                        n_sum = r_sum + i_rx_byte;
                    end else if (r_pos == POS_LENGTH) begin
                        n_length = i_rx_byte;
                        // zero length: the length byte doubles as the checksum
                        if (i_rx_byte == '0) begin
                            w_done = 1'b1;
                            w_err  = (i_rx_byte != ~r_sum);
                        end else begin
                            n_sum = r_sum + i_rx_byte;
                        end
                    end else if (r_pos >= POS_PAYLOAD) begin
                        if (r_pos == w_last_pos) begin
                            w_done = 1'b1;
                            w_err  = (i_rx_byte != ~r_sum);
                        end else begin
                            n_sum = r_sum + i_rx_byte;
                        end
                    end
                    o_has_result            = 1'b1;
                    o_result.data_byte      = i_rx_byte;
                    o_result.byte_index     = r_pos;
                    o_result.packet_done    = w_done;
                    o_result.checksum_error = w_err;
                    if (w_done) begin
                        n_armed = 1'b0;
                        n_pos   = '0;
                    end else begin
                        n_pos = r_pos + 9'd1;
                    end
                end
            end
            default: begin
                // unused kind: drop
            end
        endcase

        if (!i_valid) begin
            o_has_result = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed  <= 1'b0;
            r_pos    <= '0;
            r_length <= '0;
            r_sum    <= '0;
            r_ticks  <= '0;
        end else if (i_fire) begin
            r_armed  <= n_armed;
            r_pos    <= n_pos;
            r_length <= n_length;
            r_sum    <= n_sum;
            r_ticks  <= n_ticks;
        end
    end

    `SSPR_ASSERT_IMPLY(a_pos_range, i_clk, i_rst_n, 1'b1, r_pos <= POS_MAX, "position past end")
    `SSPR_ASSERT_IMPLY(a_idle_clear, i_clk, i_rst_n, !r_armed, r_pos == '0 && r_ticks == '0, "idle state not cleared")
    `SSPR_ASSERT_NEXT(a_end_disarms, i_clk, i_rst_n, i_fire && o_has_result && (o_result.packet_done || o_result.timed_out), !r_armed, "end of packet left receiver armed")

endmodule

`default_nettype wire
